/* rtl/hs_pkg.sv */
// Shared types, constants and functions of the HMAC-SHA-512 engine.
`timescale 1ns / 1ps

package hs_pkg;

  localparam int unsigned ROUNDS = 80;
  localparam int unsigned DIGEST_WORDS = 8;
  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;
  localparam logic [6:0] POS_LAST = 7'd127;
  localparam logic [6:0] POS_PAD_STOP = 7'd112;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  typedef enum logic [4:0] {
    S_IDLE,
    S_KBYTE,
    S_CLOSE,
    S_KEYDIG,
    S_PRIME,
    S_PDONE,
    S_MBYTE,
    S_OUTER,
    S_OUTER2,
    S_EMIT,
    S_FIN_LAT,
    S_FIN_PAD,
    S_FIN_LEN,
    S_C_LOAD,
    S_C_ROUND,
    S_C_ADD
  } state_e;

  typedef enum logic [1:0] {
    PH_COLLECT,
    PH_KEYHASH,
    PH_MSG
  } phase_e;

  typedef enum logic [3:0] {
    C_NOP,
    C_CLR_LEN,
    C_IV,
    C_LOAD,
    C_ROUND,
    C_ADD,
    C_PUT,
    C_LATCH,
    C_BLEN,
    C_OKEY_MASK,
    C_OKEY_CHAIN,
    C_PRIME,
    C_OUTER,
    C_INNER,
    C_EMIT
  } cmd_e;

  typedef enum logic [1:0] {
    B_IN,
    B_PAD,
    B_ZERO
  } bsel_e;

  typedef struct packed {
    cmd_e        cmd;
    bsel_e       bsel;
    logic [2:0]  bidx;
    logic [6:0]  ridx;
    logic [2:0]  widx;
    logic        capture;
  } ctl_t;

  typedef struct packed {
    logic pos_last;
    logic pad_stop;
    logic key_small;
    logic out_free;
  } sts_t;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] big_s0(input logic [63:0] x);
    big_s0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] big_s1(input logic [63:0] x);
    big_s1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] sml_s0(input logic [63:0] x);
    sml_s0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] sml_s1(input logic [63:0] x);
    sml_s1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  // Keeps the leading key bytes of word i of a key that is n bytes long.
  function automatic logic [63:0] key_mask(input logic [63:0] w, input logic [7:0] n,
                                           input logic [3:0] i);
    logic [7:0]  base;
    logic [7:0]  k;
    logic [63:0] m;
    base = {1'b0, i, 3'b000};
    k = (n > base) ? n - base : 8'd0;
    if (k >= 8'd8) begin
      m = '1;
    end else begin
      m = ~({64{1'b1}} >> {k[2:0], 3'b000});
    end
    key_mask = w & m;
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] t);
    case (t)
      7'd0:  round_k = 64'h428a2f98d728ae22;
      7'd1:  round_k = 64'h7137449123ef65cd;
      7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;
      7'd3:  round_k = 64'he9b5dba58189dbbc;
      7'd4:  round_k = 64'h3956c25bf348b538;
      7'd5:  round_k = 64'h59f111f1b605d019;
      7'd6:  round_k = 64'h923f82a4af194f9b;
      7'd7:  round_k = 64'hab1c5ed5da6d8118;
      7'd8:  round_k = 64'hd807aa98a3030242;
      7'd9:  round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c;
      7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f;
      7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235;
      7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2;
      7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5;
      7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275;
      7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4;
      7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab;
      7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f;
      7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2;
      7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f;
      7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc;
      7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed;
      7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de;
      7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6;
      7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364;
      7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791;
      7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218;
      7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a;
      7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8;
      7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99;
      7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63;
      7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373;
      7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc;
      7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72;
      7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28;
      7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915;
      7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c;
      7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e;
      7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba;
      7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae;
      7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84;
      7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc;
      7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6;
      7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec;
      7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = 64'h0;
    endcase
  endfunction

endpackage

/* rtl/hs_if.sv */
// Request and result channel interfaces of the HMAC-SHA-512 engine.
`timescale 1ns / 1ps

interface hs_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] data_word;
  logic [3:0]  valid_bytes;
  logic        last;

  modport source (output valid, output opcode, output data_word, output valid_bytes,
                  output last, input ready);
  modport sink (input valid, input opcode, input data_word, input valid_bytes,
                input last, output ready);
endinterface

interface hs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

/* rtl/hs_dp.sv */
// Datapath of the HMAC-SHA-512 engine: buffers, round logic, length count and result register.
`timescale 1ns / 1ps

module hs_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hs_pkg::ctl_t  ctl_i,
  input  logic [63:0]   data_word_i,
  output hs_pkg::sts_t  sts_o,
  hs_out_if.source      rsp_o
);

  logic [63:0] chain_q [8];
  logic [63:0] v_q [8];
  logic [63:0] win_q [16];
  logic [63:0] bb_q [16];
  logic [63:0] okey_q [16];
  logic [63:0] idig_q [8];
  logic [63:0] len_hi_q;
  logic [63:0] len_lo_q;
  logic [63:0] bl_hi_q;
  logic [63:0] bl_lo_q;
  logic [63:0] word_q;
  logic        out_valid_q;
  logic [63:0] out_word_q;
  logic [2:0]  out_idx_q;
  logic        out_last_q;

  logic [63:0]  t1;
  logic [63:0]  t2;
  logic [63:0]  w_next;
  logic [7:0]   put_byte;
  logic [6:0]   pos;
  logic [7:0]   key_len;
  logic [127:0] len_inc;
  logic         out_free;

  assign pos = len_lo_q[6:0];
  assign len_inc = {len_hi_q, len_lo_q} + 128'd1;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign key_len = (len_hi_q == 64'd0 && len_lo_q <= 64'd128) ? len_lo_q[7:0] : 8'd128;

  always_comb begin
    t1 = v_q[7] + hs_pkg::big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + hs_pkg::round_k(ctl_i.ridx) + win_q[0];
    t2 = hs_pkg::big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_next = win_q[0] + hs_pkg::sml_s0(win_q[1]) + win_q[9] + hs_pkg::sml_s1(win_q[14]);
  end

  always_comb begin
    case (ctl_i.bsel)
      hs_pkg::B_IN:   put_byte = word_q[{~ctl_i.bidx, 3'b000} +: 8];
      hs_pkg::B_PAD:  put_byte = 8'h80;
      hs_pkg::B_ZERO: put_byte = 8'h00;
      default:        put_byte = 8'h00;
    endcase
  end

  assign sts_o.pos_last = (pos == hs_pkg::POS_LAST);
  assign sts_o.pad_stop = (pos == hs_pkg::POS_PAD_STOP);
  assign sts_o.key_small = (len_hi_q == 64'd0) && (len_lo_q < 64'd128);
  assign sts_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= hs_pkg::IV[i];
      end
      len_hi_q <= '0;
      len_lo_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.cmd == hs_pkg::C_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (ctl_i.cmd)
        hs_pkg::C_CLR_LEN: begin
          len_hi_q <= '0;
          len_lo_q <= '0;
        end
        hs_pkg::C_IV: begin
          for (int i = 0; i < 8; i++) begin
            chain_q[i] <= hs_pkg::IV[i];
          end
        end
        hs_pkg::C_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain_q[i] <= chain_q[i] + v_q[i];
          end
        end
        hs_pkg::C_PUT: begin
          len_hi_q <= len_inc[127:64];
          len_lo_q <= len_inc[63:0];
        end
        hs_pkg::C_PRIME: begin
          for (int i = 0; i < 8; i++) begin
            chain_q[i] <= hs_pkg::IV[i];
          end
          len_hi_q <= '0;
          len_lo_q <= 64'd128;
        end
        hs_pkg::C_OUTER: begin
          for (int i = 0; i < 8; i++) begin
            chain_q[i] <= hs_pkg::IV[i];
          end
        end
        hs_pkg::C_INNER: begin
          len_hi_q <= '0;
          len_lo_q <= 64'd192;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      word_q <= data_word_i;
    end
    case (ctl_i.cmd)
      hs_pkg::C_LOAD: begin
        for (int i = 0; i < 8; i++) begin
          v_q[i] <= chain_q[i];
        end
        for (int i = 0; i < 16; i++) begin
          win_q[i] <= bb_q[i];
        end
      end
      hs_pkg::C_ROUND: begin
        v_q[0] <= t1 + t2;
        v_q[1] <= v_q[0];
        v_q[2] <= v_q[1];
        v_q[3] <= v_q[2];
        v_q[4] <= v_q[3] + t1;
        v_q[5] <= v_q[4];
        v_q[6] <= v_q[5];
        v_q[7] <= v_q[6];
        for (int i = 0; i < 15; i++) begin
          win_q[i] <= win_q[i + 1];
        end
        win_q[15] <= w_next;
      end
      hs_pkg::C_PUT: begin
        bb_q[pos[6:3]][{~pos[2:0], 3'b000} +: 8] <= put_byte;
      end
      hs_pkg::C_LATCH: begin
        bl_hi_q <= {len_hi_q[60:0], len_lo_q[63:61]};
        bl_lo_q <= {len_lo_q[60:0], 3'b000};
      end
      hs_pkg::C_BLEN: begin
        bb_q[14] <= bl_hi_q;
        bb_q[15] <= bl_lo_q;
      end
      hs_pkg::C_OKEY_MASK: begin
        for (int i = 0; i < 16; i++) begin
          okey_q[i] <= hs_pkg::key_mask(bb_q[i], key_len, 4'(i)) ^ {8{hs_pkg::OPAD}};
        end
      end
      hs_pkg::C_OKEY_CHAIN: begin
        for (int i = 0; i < 8; i++) begin
          okey_q[i] <= chain_q[i] ^ {8{hs_pkg::OPAD}};
          okey_q[i + 8] <= {8{hs_pkg::OPAD}};
        end
      end
      hs_pkg::C_PRIME: begin
        for (int i = 0; i < 16; i++) begin
          bb_q[i] <= okey_q[i] ^ {8{hs_pkg::IPAD ^ hs_pkg::OPAD}};
        end
      end
      hs_pkg::C_OUTER: begin
        for (int i = 0; i < 8; i++) begin
          idig_q[i] <= chain_q[i];
        end
        for (int i = 0; i < 16; i++) begin
          bb_q[i] <= okey_q[i];
        end
      end
      hs_pkg::C_INNER: begin
        for (int i = 0; i < 8; i++) begin
          bb_q[i] <= idig_q[i];
        end
      end
      hs_pkg::C_EMIT: begin
        out_word_q <= chain_q[ctl_i.widx];
        out_idx_q <= ctl_i.widx;
        out_last_q <= (ctl_i.widx == 3'(hs_pkg::DIGEST_WORDS - 1));
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.digest_word = out_word_q;
  assign rsp_o.word_index = out_idx_q;
  assign rsp_o.last_word = out_last_q;

endmodule

/* rtl/hs_ctrl.sv */
// Controller state machine of the HMAC-SHA-512 engine.
`timescale 1ns / 1ps

module hs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          opcode_i,
  input  logic [3:0]    valid_bytes_i,
  input  logic          last_i,
  output logic          in_ready_o,
  input  hs_pkg::sts_t  sts_i,
  output hs_pkg::ctl_t  ctl_o
);

  hs_pkg::state_e state_q, state_d;
  hs_pkg::state_e cret_q, cret_d;
  hs_pkg::state_e fret_q, fret_d;
  hs_pkg::phase_e phase_q, phase_d;
  logic       op_q, op_d;
  logic [3:0] n_q, n_d;
  logic       last_q, last_d;
  logic [3:0] bi_q, bi_d;
  logic [6:0] rnd_q, rnd_d;
  logic [2:0] widx_q, widx_d;
  logic       first_q, first_d;
  logic       emitted_q, emitted_d;

  always_comb begin
    state_d = state_q;
    cret_d = cret_q;
    fret_d = fret_q;
    phase_d = phase_q;
    op_d = op_q;
    n_d = n_q;
    last_d = last_q;
    bi_d = bi_q;
    rnd_d = rnd_q;
    widx_d = widx_q;
    first_d = first_q;
    emitted_d = emitted_q;
    case (state_q)
      hs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d = opcode_i;
          n_d = (valid_bytes_i > 4'd8) ? 4'd8 : valid_bytes_i;
          last_d = last_i;
          bi_d = '0;
          emitted_d = 1'b0;
          if (!opcode_i) begin
            if (phase_q == hs_pkg::PH_MSG) begin
              phase_d = hs_pkg::PH_COLLECT;
            end
            state_d = hs_pkg::S_KBYTE;
          end else if (phase_q != hs_pkg::PH_MSG) begin
            state_d = hs_pkg::S_CLOSE;
          end else begin
            state_d = hs_pkg::S_MBYTE;
          end
        end
      end
      hs_pkg::S_KBYTE: begin
        if (bi_q < n_q) begin
          if (phase_q == hs_pkg::PH_KEYHASH) begin
            bi_d = bi_q + 4'd1;
            if (sts_i.pos_last) begin
              cret_d = hs_pkg::S_KBYTE;
              state_d = hs_pkg::S_C_LOAD;
            end
          end else if (sts_i.key_small) begin
            bi_d = bi_q + 4'd1;
          end else begin
            phase_d = hs_pkg::PH_KEYHASH;
            cret_d = hs_pkg::S_KBYTE;
            state_d = hs_pkg::S_C_LOAD;
          end
        end else begin
          state_d = last_q ? hs_pkg::S_CLOSE : hs_pkg::S_IDLE;
        end
      end
      hs_pkg::S_CLOSE: begin
        if (phase_q == hs_pkg::PH_KEYHASH) begin
          fret_d = hs_pkg::S_KEYDIG;
          state_d = hs_pkg::S_FIN_LAT;
        end else begin
          state_d = hs_pkg::S_PRIME;
        end
      end
      hs_pkg::S_KEYDIG: state_d = hs_pkg::S_PRIME;
      hs_pkg::S_PRIME: begin
        phase_d = hs_pkg::PH_MSG;
        cret_d = hs_pkg::S_PDONE;
        state_d = hs_pkg::S_C_LOAD;
      end
      hs_pkg::S_PDONE: begin
        state_d = (op_q && !emitted_q) ? hs_pkg::S_MBYTE : hs_pkg::S_IDLE;
      end
      hs_pkg::S_MBYTE: begin
        if (bi_q < n_q) begin
          bi_d = bi_q + 4'd1;
          if (sts_i.pos_last) begin
            cret_d = hs_pkg::S_MBYTE;
            state_d = hs_pkg::S_C_LOAD;
          end
        end else if (last_q) begin
          fret_d = hs_pkg::S_OUTER;
          state_d = hs_pkg::S_FIN_LAT;
        end else begin
          state_d = hs_pkg::S_IDLE;
        end
      end
      hs_pkg::S_OUTER: begin
        cret_d = hs_pkg::S_OUTER2;
        state_d = hs_pkg::S_C_LOAD;
      end
      hs_pkg::S_OUTER2: begin
        fret_d = hs_pkg::S_EMIT;
        state_d = hs_pkg::S_FIN_LAT;
      end
      hs_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == 3'(hs_pkg::DIGEST_WORDS - 1)) begin
            emitted_d = 1'b1;
            state_d = hs_pkg::S_PRIME;
          end
        end
      end
      hs_pkg::S_FIN_LAT: begin
        first_d = 1'b1;
        state_d = hs_pkg::S_FIN_PAD;
      end
      hs_pkg::S_FIN_PAD: begin
        if (first_q || !sts_i.pad_stop) begin
          first_d = 1'b0;
          if (sts_i.pos_last) begin
            cret_d = hs_pkg::S_FIN_PAD;
            state_d = hs_pkg::S_C_LOAD;
          end
        end else begin
          state_d = hs_pkg::S_FIN_LEN;
        end
      end
      hs_pkg::S_FIN_LEN: begin
        cret_d = fret_q;
        state_d = hs_pkg::S_C_LOAD;
      end
      hs_pkg::S_C_LOAD: begin
        rnd_d = '0;
        state_d = hs_pkg::S_C_ROUND;
      end
      hs_pkg::S_C_ROUND: begin
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'(hs_pkg::ROUNDS - 1)) begin
          rnd_d = '0;
          state_d = hs_pkg::S_C_ADD;
        end
      end
      hs_pkg::S_C_ADD: state_d = cret_q;
      default: state_d = hs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ctl_o.cmd = hs_pkg::C_NOP;
    ctl_o.bsel = hs_pkg::B_IN;
    ctl_o.bidx = bi_q[2:0];
    ctl_o.ridx = rnd_q;
    ctl_o.widx = widx_q;
    ctl_o.capture = 1'b0;
    case (state_q)
      hs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.capture = in_valid_i;
        if (in_valid_i && !opcode_i && phase_q == hs_pkg::PH_MSG) begin
          ctl_o.cmd = hs_pkg::C_CLR_LEN;
        end
      end
      hs_pkg::S_KBYTE: begin
        if (bi_q < n_q) begin
          if (phase_q == hs_pkg::PH_KEYHASH || sts_i.key_small) begin
            ctl_o.cmd = hs_pkg::C_PUT;
          end else begin
            ctl_o.cmd = hs_pkg::C_IV;
          end
        end
      end
      hs_pkg::S_CLOSE: begin
        if (phase_q != hs_pkg::PH_KEYHASH) begin
          ctl_o.cmd = hs_pkg::C_OKEY_MASK;
        end
      end
      hs_pkg::S_KEYDIG: ctl_o.cmd = hs_pkg::C_OKEY_CHAIN;
      hs_pkg::S_PRIME:  ctl_o.cmd = hs_pkg::C_PRIME;
      hs_pkg::S_MBYTE: begin
        if (bi_q < n_q) begin
          ctl_o.cmd = hs_pkg::C_PUT;
        end
      end
      hs_pkg::S_OUTER:  ctl_o.cmd = hs_pkg::C_OUTER;
      hs_pkg::S_OUTER2: ctl_o.cmd = hs_pkg::C_INNER;
      hs_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          ctl_o.cmd = hs_pkg::C_EMIT;
        end
      end
      hs_pkg::S_FIN_LAT: ctl_o.cmd = hs_pkg::C_LATCH;
      hs_pkg::S_FIN_PAD: begin
        if (first_q) begin
          ctl_o.cmd = hs_pkg::C_PUT;
          ctl_o.bsel = hs_pkg::B_PAD;
        end else if (!sts_i.pad_stop) begin
          ctl_o.cmd = hs_pkg::C_PUT;
          ctl_o.bsel = hs_pkg::B_ZERO;
        end
      end
      hs_pkg::S_FIN_LEN: ctl_o.cmd = hs_pkg::C_BLEN;
      hs_pkg::S_C_LOAD:  ctl_o.cmd = hs_pkg::C_LOAD;
      hs_pkg::S_C_ROUND: ctl_o.cmd = hs_pkg::C_ROUND;
      hs_pkg::S_C_ADD:   ctl_o.cmd = hs_pkg::C_ADD;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hs_pkg::S_IDLE;
      cret_q <= hs_pkg::S_IDLE;
      fret_q <= hs_pkg::S_IDLE;
      phase_q <= hs_pkg::PH_COLLECT;
      op_q <= 1'b0;
      n_q <= '0;
      last_q <= 1'b0;
      bi_q <= '0;
      rnd_q <= '0;
      widx_q <= '0;
      first_q <= 1'b0;
      emitted_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cret_q <= cret_d;
      fret_q <= fret_d;
      phase_q <= phase_d;
      op_q <= op_d;
      n_q <= n_d;
      last_q <= last_d;
      bi_q <= bi_d;
      rnd_q <= rnd_d;
      widx_q <= widx_d;
      first_q <= first_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

/* rtl/hmac_sha512_engine.sv */
// Top level of the HMAC-SHA-512 engine: controller, datapath and channel wiring.
// A request word's valid bytes are written one per cycle; no new word is taken until all
// are in, and each filled 128-byte block is compressed (load, 80 rounds at one per cycle,
// chain add) in between. A last message word adds padding at one byte per cycle (held while
// a block compresses) and three or four compressions before the first digest word is offered.
// Reset is asynchronous and active low; it clears control state and the length count, loads
// the initial hash values, and the engine then waits for a key with an all-zero key held.
`timescale 1ns / 1ps

module hmac_sha512_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  hs_in_if.sink     req_i,
  hs_out_if.source  rsp_o
);

  hs_pkg::ctl_t ctl;
  hs_pkg::sts_t sts;
  logic         in_ready;

  assign req_i.ready = in_ready;

  hs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_i.valid),
    .opcode_i      (req_i.opcode),
    .valid_bytes_i (req_i.valid_bytes),
    .last_i        (req_i.last),
    .in_ready_o    (in_ready),
    .sts_i         (sts),
    .ctl_o         (ctl)
  );

  hs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .data_word_i (req_i.data_word),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule
